// ===== rtl/ddft_pkg.sv =====
// shared constants, twiddle table and helper types for the direct dft block
package ddft_pkg;

	localparam int FRAME_LEN = 64;
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam int BIN_W     = 6;
	localparam int SAMPLE_W  = 24;
	localparam int TW_W      = 16;
	localparam int PROD_W    = SAMPLE_W + TW_W;
	localparam int ACC_W     = 48;
	localparam int PHASE_W   = 8;

	localparam int FWD_SHIFT = 15;
	localparam int INV_SHIFT = 15 + $clog2(FRAME_LEN);

	typedef logic signed [TW_W-1:0] tw_val_t;
	typedef tw_val_t qsin_tab_t [0:64];
	typedef logic [PHASE_W-1:0] phase_tab_t [0:FRAME_LEN-1];

	typedef struct packed {
		tw_val_t c;
		tw_val_t s;
	} tw_t;

	// sin(2*pi*j/256) in q1.15, quarter wave plus end point
	localparam qsin_tab_t QSIN = '{
		16'sd0,     16'sd804,   16'sd1608,  16'sd2411,
		16'sd3212,  16'sd4011,  16'sd4808,  16'sd5602,
		16'sd6393,  16'sd7180,  16'sd7962,  16'sd8740,
		16'sd9512,  16'sd10279, 16'sd11039, 16'sd11793,
		16'sd12540, 16'sd13279, 16'sd14010, 16'sd14733,
		16'sd15447, 16'sd16151, 16'sd16846, 16'sd17531,
		16'sd18205, 16'sd18868, 16'sd19520, 16'sd20160,
		16'sd20788, 16'sd21403, 16'sd22006, 16'sd22595,
		16'sd23170, 16'sd23732, 16'sd24279, 16'sd24812,
		16'sd25330, 16'sd25832, 16'sd26319, 16'sd26790,
		16'sd27245, 16'sd27684, 16'sd28106, 16'sd28511,
		16'sd28899, 16'sd29269, 16'sd29622, 16'sd29957,
		16'sd30273, 16'sd30572, 16'sd30852, 16'sd31114,
		16'sd31357, 16'sd31581, 16'sd31786, 16'sd31972,
		16'sd32138, 16'sd32285, 16'sd32413, 16'sd32521,
		16'sd32610, 16'sd32679, 16'sd32728, 16'sd32758,
		16'sd32767
	};

	// phase step out of 256 for each kernel index, rounded to nearest
	function automatic phase_tab_t make_phase_tab();
		phase_tab_t tab;
		for (int i = 0; i < FRAME_LEN; i++) begin
			tab[i] = PHASE_W'((256 * i + FRAME_LEN / 2) / FRAME_LEN);
		end
		return tab;
	endfunction

	localparam phase_tab_t PHASE_TAB = make_phase_tab();

	// cosine and sine of 2*pi*p/256 from the quarter wave table
	function automatic tw_t twiddle(input logic [PHASE_W-1:0] p);
		tw_t        t;
		logic [6:0] r;
		logic [6:0] rc;
		r  = {1'b0, p[5:0]};
		rc = 7'd64 - r;
		unique case (p[7:6])
			2'b00: begin
				t.c = QSIN[rc];
				t.s = QSIN[r];
			end
			2'b01: begin
				t.c = -QSIN[r];
				t.s = QSIN[rc];
			end
			2'b10: begin
				t.c = -QSIN[rc];
				t.s = -QSIN[r];
			end
			default: begin
				t.c = QSIN[r];
				t.s = -QSIN[rc];
			end
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/direct_dft_forward_inverse.sv =====
// direct n-point dft, forward or inverse, on one shared complex multiply-accumulate unit
//
// usage
// - samples come in on start/in_re/in_im; an item is taken at a clock edge with start high
//   and busy low. the frame store fills in order, FRAME_LEN items per frame
// - the item that completes a frame starts the transform; busy stays high until every bin
//   of that frame is out
// - direction is written on the cfg channel (cfg_valid/cfg_ready/cfg_data, ready always
//   high); its value at the last item of a frame picks the kernel for that frame
// - bins leave in index order on out_valid/out_re/out_im/bin_index/last, one cycle each,
//   last marks the final bin; the receiver cannot stall, nothing waits for it
// timing
// - one complex multiply-accumulate per cycle while the transform runs: a frame is loaded, then
//   every (m, n) pair is issued to the shared mac unit, then the pipeline drains; no new item
//   is taken until the frame is done
// - a bin's last product passes store read and twiddle, partial products, accumulator and
//   output register before the bin appears; bins of a frame come out evenly spaced
// reset
// - arst_n clears the sequencer, fill count, pipeline valids and direction (forward);
//   the frame store is not cleared, every frame writes it fully before it is read
module direct_dft_forward_inverse (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_re,
	input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_im,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,
	output logic                                 out_valid,
	output logic signed [ddft_pkg::SAMPLE_W-1:0] out_re,
	output logic signed [ddft_pkg::SAMPLE_W-1:0] out_im,
	output logic        [ddft_pkg::BIN_W-1:0]    bin_index,
	output logic                                 last
);
	import ddft_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_CALC  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	localparam logic [IDX_W-1:0] N_LAST = IDX_W'(FRAME_LEN - 1);
	localparam logic signed [ACC_W:0] RND_FWD = (ACC_W+1)'(1) << (FWD_SHIFT - 1);
	localparam logic signed [ACC_W:0] RND_INV = (ACC_W+1)'(1) << (INV_SHIFT - 1);
	localparam logic signed [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// rounded shift (scale by 1/N on inverse) and saturation to sample width
	function automatic logic signed [SAMPLE_W-1:0] round_sat(
		input logic signed [ACC_W-1:0] a,
		input logic                    inv
	);
		logic signed [ACC_W:0] ext;
		logic signed [ACC_W:0] shd;
		ext = (ACC_W+1)'(a);
		if (inv) begin
			shd = (ext + RND_INV) >>> INV_SHIFT;
		end else begin
			shd = (ext + RND_FWD) >>> FWD_SHIFT;
		end
		if (shd > (ACC_W+1)'(SAT_HI)) begin
			return SAT_HI;
		end else if (shd < (ACC_W+1)'(SAT_LO)) begin
			return SAT_LO;
		end
		return SAMPLE_W'(shd);
	endfunction

	// frame store
	logic signed [SAMPLE_W-1:0] mem_re [0:FRAME_LEN-1];
	logic signed [SAMPLE_W-1:0] mem_im [0:FRAME_LEN-1];

	// sequencer
	state_t           state_q;
	logic [IDX_W-1:0] load_cnt_q;
	logic             dir_q;        // register as written
	logic             frame_dir_q;  // direction latched for the running frame
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] m_q;
	logic [IDX_W-1:0] k_q;          // (m*n) mod N, stepped by m
	logic [IDX_W:0]   k_sum;
	logic [IDX_W-1:0] k_next;
	logic             accept;
	logic             issue;

	// stage 1: store read and twiddle
	logic                       v_s1, first_s1, last_s1;
	logic [IDX_W-1:0]           bin_s1;
	logic signed [SAMPLE_W-1:0] xr_s1, xi_s1;
	tw_val_t                    c_s1, sn_s1;
	tw_t                        tw;

	// stage 2: four partial products
	logic                     v_s2, first_s2, last_s2;
	logic [IDX_W-1:0]         bin_s2;
	logic signed [PROD_W-1:0] p_rc_s2, p_is_s2, p_rs_s2, p_ic_s2;

	// stage 3: accumulator
	logic                    v_s3, done_s3;
	logic [IDX_W-1:0]        bin_s3;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0] acc_re_base, acc_im_base;

	// output register
	logic                       out_valid_q, last_q;
	logic [BIN_W-1:0]           bin_q;
	logic signed [SAMPLE_W-1:0] out_re_q, out_im_q;

	assign busy      = (state_q != ST_LOAD);
	assign cfg_ready = 1'b1;
	assign accept    = start && (state_q == ST_LOAD);
	assign issue     = (state_q == ST_CALC);

	// next kernel index, one compare and subtract since k and m are both below N
	always_comb begin
		k_sum  = {1'b0, k_q} + {1'b0, m_q};
		k_next = (k_sum >= (IDX_W+1)'(FRAME_LEN)) ?
			IDX_W'(k_sum - (IDX_W+1)'(FRAME_LEN)) : IDX_W'(k_sum);
	end

	assign tw = twiddle(PHASE_TAB[k_q]);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			dir_q <= cfg_data;
		end
	end

	// sequencer: load items, then walk every (m, n) pair, then let the pipe drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			frame_dir_q <= 1'b0;
			n_q         <= '0;
			m_q         <= '0;
			k_q         <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (load_cnt_q == N_LAST) begin
							load_cnt_q  <= '0;
							frame_dir_q <= dir_q;
							n_q         <= '0;
							m_q         <= '0;
							k_q         <= '0;
							state_q     <= ST_CALC;
						end else begin
							load_cnt_q <= load_cnt_q + 1'b1;
						end
					end
				end
				ST_CALC: begin
					if (n_q == N_LAST) begin
						n_q <= '0;
						k_q <= '0;
						m_q <= m_q + 1'b1;
						if (m_q == N_LAST) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						n_q <= n_q + 1'b1;
						k_q <= k_next;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// frame store write and registered read
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_re[load_cnt_q] <= in_re;
			mem_im[load_cnt_q] <= in_im;
		end
		if (issue) begin
			xr_s1 <= mem_re[n_q];
			xi_s1 <= mem_im[n_q];
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			done_s3     <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			done_s3     <= v_s2 && last_s2;
			out_valid_q <= v_s3 && done_s3;
			last_q      <= v_s3 && done_s3 && (bin_s3 == N_LAST);
		end
	end

	// forward kernel uses the conjugate, so the sine flips sign
	always_ff @(posedge clk) begin
		first_s1 <= (n_q == '0);
		last_s1  <= (n_q == N_LAST);
		bin_s1   <= m_q;
		c_s1     <= tw.c;
		sn_s1    <= frame_dir_q ? tw.s : -tw.s;
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		bin_s2   <= bin_s1;
		p_rc_s2  <= xr_s1 * c_s1;
		p_is_s2  <= xi_s1 * sn_s1;
		p_rs_s2  <= xr_s1 * sn_s1;
		p_ic_s2  <= xi_s1 * c_s1;
	end

	// the first product of a bin restarts the sum
	assign acc_re_base = first_s2 ? '0 : acc_re_q;
	assign acc_im_base = first_s2 ? '0 : acc_im_q;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_re_q <= acc_re_base + ACC_W'(p_rc_s2) - ACC_W'(p_is_s2);
			acc_im_q <= acc_im_base + ACC_W'(p_rs_s2) + ACC_W'(p_ic_s2);
		end
		bin_s3 <= bin_s2;
	end

	always_ff @(posedge clk) begin
		if (v_s3 && done_s3) begin
			out_re_q <= round_sat(acc_re_q, frame_dir_q);
			out_im_q <= round_sat(acc_im_q, frame_dir_q);
			bin_q    <= BIN_W'(bin_s3);
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign bin_index = bin_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// bins only appear while the block holds off new items
	a_out_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("result strobe outside a transform");

	// last marks the top bin
	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> (out_valid && (bin_index == BIN_W'(FRAME_LEN - 1))))
		else $error("last flag on a bin other than the final one");

	// the item that fills the frame starts the transform
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (load_cnt_q == N_LAST)) |=> busy)
		else $error("full frame did not start a transform");

	// bins of a frame come out evenly spaced
	a_bin_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> ##FRAME_LEN out_valid)
		else $error("bins of a frame not evenly spaced");
`endif

endmodule
